// ===== design/lmc_pkg.sv =====
// Shared constants, types and the peak test for the 3x3 local maxima counter.
package lmc_pkg;

    // Frame limits and field widths
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int NCOLS_BITS  = 11;
    localparam int NROWS_BITS  = 13;
    localparam int COUNT_BITS  = 23;

    // APB register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic
    {
        REG_NUM_ROWS,
        REG_NUM_COLS
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // 3x3 neighborhood, [row][col], center at [1][1]
    typedef sample_t window_t [3][3];

    // Frame geometry seen by the datapath
    typedef struct packed
    {
        logic                clear;
        logic [ROW_BITS-1:0] last_row;
        logic [COL_BITS-1:0] last_col;
    } cfg_t;

    // One sample with its column from the line stores and position flags
    typedef struct packed
    {
        sample_t sample;
        sample_t above1;
        sample_t above2;
        logic    row_ge1;
        logic    row_ge2;
        logic    col_ge1;
        logic    col_ge2;
        logic    row_last;
        logic    col_last;
    } item_t;

    // Center is a peak when no in-bounds neighbor is strictly greater
    function automatic logic is_peak(input window_t win, input logic [2:0] row_ok,
                                     input logic [2:0] col_ok);
        logic peak;
        peak = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1) && row_ok[i] && col_ok[j] &&
                    ($signed(win[i][j]) > $signed(win[1][1])))
                begin
                    peak = 1'b0;
                end
            end
        end
        return peak;
    endfunction

endpackage

// ===== design/lmc_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port (read-first).
module lmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lmc_cfg.sv =====
// APB register block: frame size registers and the derived last row/column indexes.
module lmc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lmc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lmc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lmc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                             pready,
    output lmc_pkg::cfg_t                    cfg
);

    logic [lmc_pkg::NROWS_BITS-1:0] num_rows_reg;
    logic [lmc_pkg::NCOLS_BITS-1:0] num_cols_reg;
    logic                           wr_en;
    lmc_pkg::reg_idx_t              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lmc_pkg::reg_idx_t'(paddr[2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= lmc_pkg::NROWS_BITS'(1);
            num_cols_reg <= lmc_pkg::NCOLS_BITS'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lmc_pkg::REG_NUM_ROWS: num_rows_reg <= pwdata[lmc_pkg::NROWS_BITS-1:0];
                lmc_pkg::REG_NUM_COLS: num_cols_reg <= pwdata[lmc_pkg::NCOLS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            lmc_pkg::REG_NUM_ROWS: prdata = lmc_pkg::APB_DATA_BITS'(num_rows_reg);
            lmc_pkg::REG_NUM_COLS: prdata = lmc_pkg::APB_DATA_BITS'(num_cols_reg);
            default:               prdata = '0;
        endcase
    end

    // Zero counts as one, oversize counts as the maximum
    always_comb
    begin
        cfg.clear = wr_en;
        if (num_rows_reg == '0)
        begin
            cfg.last_row = '0;
        end
        else if (num_rows_reg > lmc_pkg::NROWS_BITS'(lmc_pkg::MAX_ROWS))
        begin
            cfg.last_row = lmc_pkg::ROW_BITS'(lmc_pkg::MAX_ROWS - 1);
        end
        else
        begin
            cfg.last_row = lmc_pkg::ROW_BITS'(num_rows_reg - lmc_pkg::NROWS_BITS'(1));
        end

        if (num_cols_reg == '0)
        begin
            cfg.last_col = '0;
        end
        else if (num_cols_reg > lmc_pkg::NCOLS_BITS'(lmc_pkg::MAX_COLS))
        begin
            cfg.last_col = lmc_pkg::COL_BITS'(lmc_pkg::MAX_COLS - 1);
        end
        else
        begin
            cfg.last_col = lmc_pkg::COL_BITS'(num_cols_reg - lmc_pkg::NCOLS_BITS'(1));
        end
    end

endmodule

// ===== design/lmc_ingest.sv =====
// Input stage: raster position counters, two ping-pong line stores and the input register.
module lmc_ingest (
    input  logic            clk,
    input  logic            rst_n,
    input  lmc_pkg::cfg_t   cfg,
    input  logic            sample_valid,
    output logic            sample_stall,
    input  lmc_pkg::sample_t sample,
    input  logic            take,
    output logic            item_valid,
    output lmc_pkg::item_t  item
);

    logic [lmc_pkg::ROW_BITS-1:0] row_reg;
    logic [lmc_pkg::COL_BITS-1:0] col_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    lmc_pkg::sample_t             s1_sample_reg;
    logic                         s1_parity_reg;
    logic                         s1_row_ge1_reg;
    logic                         s1_row_ge2_reg;
    logic                         s1_col_ge1_reg;
    logic                         s1_col_ge2_reg;
    logic                         s1_row_last_reg;
    logic                         s1_col_last_reg;
    logic                         accept;
    logic                         row_last;
    logic                         col_last;
    lmc_pkg::sample_t             ram0_q;
    lmc_pkg::sample_t             ram1_q;

    assign sample_stall  = s1_valid_reg && !take;
    assign accept        = sample_valid && !sample_stall;
    assign row_last      = (row_reg == cfg.last_row);
    assign col_last      = (col_reg == cfg.last_col);
    assign s1_valid_next = accept || (s1_valid_reg && !take);

    // Position of the next sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg.clear)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + lmc_pkg::ROW_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + lmc_pkg::COL_BITS'(1);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg   <= sample;
            s1_parity_reg   <= row_reg[0];
            s1_row_ge1_reg  <= (row_reg != '0);
            s1_row_ge2_reg  <= (row_reg > lmc_pkg::ROW_BITS'(1));
            s1_col_ge1_reg  <= (col_reg != '0);
            s1_col_ge2_reg  <= (col_reg > lmc_pkg::COL_BITS'(1));
            s1_row_last_reg <= row_last;
            s1_col_last_reg <= col_last;
        end
    end

    // Even rows go to store 0, odd rows to store 1; both read at the column
    lmc_ram #(
        .WIDTH (lmc_pkg::SAMPLE_BITS),
        .DEPTH (lmc_pkg::MAX_COLS)
    ) u_line0 (
        .clk   (clk),
        .we    (accept && !row_reg[0]),
        .waddr (col_reg),
        .wdata (sample),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram0_q)
    );

    lmc_ram #(
        .WIDTH (lmc_pkg::SAMPLE_BITS),
        .DEPTH (lmc_pkg::MAX_COLS)
    ) u_line1 (
        .clk   (clk),
        .we    (accept && row_reg[0]),
        .waddr (col_reg),
        .wdata (sample),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram1_q)
    );

    // Row above sits in the other store, two above in the one just overwritten
    always_comb
    begin
        item.sample   = s1_sample_reg;
        item.above1   = s1_parity_reg ? ram0_q : ram1_q;
        item.above2   = s1_parity_reg ? ram1_q : ram0_q;
        item.row_ge1  = s1_row_ge1_reg;
        item.row_ge2  = s1_row_ge2_reg;
        item.col_ge1  = s1_col_ge1_reg;
        item.col_ge2  = s1_col_ge2_reg;
        item.row_last = s1_row_last_reg;
        item.col_last = s1_col_last_reg;
    end

    assign item_valid = s1_valid_reg;

endmodule

// ===== design/lmc_peak.sv =====
// Window registers, up to four peak tests per sample, running count and result register.
module lmc_peak (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lmc_pkg::cfg_t                  cfg,
    input  logic                           item_valid,
    input  lmc_pkg::item_t                 item,
    output logic                           take,
    output logic                           count_valid,
    input  logic                           count_stall,
    output logic [lmc_pkg::COUNT_BITS-1:0] maxima_count
);

    lmc_pkg::sample_t               m1_reg [3];
    lmc_pkg::sample_t               m2_reg [3];
    lmc_pkg::sample_t               live [3];
    lmc_pkg::window_t               w_mid;
    lmc_pkg::window_t               w_right;
    lmc_pkg::window_t               w_bot;
    lmc_pkg::window_t               w_corner;
    logic                           hit_mid;
    logic                           hit_right;
    logic                           hit_bot;
    logic                           hit_corner;
    logic [2:0]                     hits;
    logic [lmc_pkg::COUNT_BITS-1:0] total;
    logic [lmc_pkg::COUNT_BITS-1:0] running_reg;
    logic [lmc_pkg::COUNT_BITS-1:0] count_reg;
    logic                           count_valid_reg;
    logic                           frame_end;

    // Column arriving now: rows r-2, r-1, r
    assign live[0] = item.above2;
    assign live[1] = item.above1;
    assign live[2] = item.sample;

    assign frame_end = item.row_last && item.col_last;
    assign take      = item_valid && (!frame_end || !count_valid_reg || !count_stall);

    // Neighborhoods: columns m2/m1/live are c-2, c-1, c; rows r-2, r-1, r
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // center (r-1, c-1)
            w_mid[i][0]   = m2_reg[i];
            w_mid[i][1]   = m1_reg[i];
            w_mid[i][2]   = live[i];
            // center (r-1, c) on the last column
            w_right[i][0] = m1_reg[i];
            w_right[i][1] = live[i];
            w_right[i][2] = live[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            // on the last row the window moves down by one; row below is padding
            w_bot[i][0]    = m2_reg[(i == 0) ? 1 : 2];
            w_bot[i][1]    = m1_reg[(i == 0) ? 1 : 2];
            w_bot[i][2]    = live[(i == 0) ? 1 : 2];
            w_corner[i][0] = m1_reg[(i == 0) ? 1 : 2];
            w_corner[i][1] = live[(i == 0) ? 1 : 2];
            w_corner[i][2] = live[(i == 0) ? 1 : 2];
        end
    end

    // Peak tests; out-of-frame neighbors are masked by row/col flags
    always_comb
    begin
        hit_mid    = item.row_ge1 && item.col_ge1 &&
                     lmc_pkg::is_peak(w_mid, {2'b11, item.row_ge2}, {2'b11, item.col_ge2});
        hit_right  = item.row_ge1 && item.col_last &&
                     lmc_pkg::is_peak(w_right, {2'b11, item.row_ge2}, {2'b01, item.col_ge1});
        hit_bot    = item.row_last && item.col_ge1 &&
                     lmc_pkg::is_peak(w_bot, {2'b01, item.row_ge1}, {2'b11, item.col_ge2});
        hit_corner = frame_end &&
                     lmc_pkg::is_peak(w_corner, {2'b01, item.row_ge1}, {2'b01, item.col_ge1});
        hits       = 3'(hit_mid) + 3'(hit_right) + 3'(hit_bot) + 3'(hit_corner);
        total      = running_reg + lmc_pkg::COUNT_BITS'(hits);
    end

    // Window shift
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m2_reg[i] <= m1_reg[i];
                m1_reg[i] <= live[i];
            end
        end
    end

    // Running count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= '0;
            count_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.clear)
            begin
                running_reg <= '0;
            end
            else if (take)
            begin
                running_reg <= frame_end ? '0 : total;
            end

            if (take && frame_end)
            begin
                count_valid_reg <= 1'b1;
            end
            else if (!count_stall)
            begin
                count_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take && frame_end)
        begin
            count_reg <= total;
        end
    end

    assign count_valid  = count_valid_reg;
    assign maxima_count = count_reg;

endmodule

// ===== design/local_maxima_counter_3x3.sv =====
// Top level of the 3x3 local maxima counter.
// Samples arrive in raster order, one per clock unless sample_stall holds them; the user
// sets the frame size (num_rows at address 0, num_cols at address 4) over APB only while
// the block is idle, which the block does not enforce. Any write restarts the frame. Two
// line stores of 1024 x 16 bits (both read, one written per sample) and a 3x3 window feed
// up to four parallel 8-neighbor tests, so the rows above, the last column and the last
// row are all judged as samples stream in. The count is registered as the last sample
// leaves the input register; a new frame needs no gap unless a held result stalls input.
// Line stores need no clearing after reset: neighbors outside the frame are masked.
module local_maxima_counter_3x3 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lmc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lmc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lmc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                             pready,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [lmc_pkg::SAMPLE_BITS-1:0]  sample,
    output logic                             count_valid,
    input  logic                             count_stall,
    output logic [lmc_pkg::COUNT_BITS-1:0]   maxima_count
);

    lmc_pkg::cfg_t  cfg;
    lmc_pkg::item_t item;
    logic           item_valid;
    logic           take;

    lmc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmc_ingest u_ingest (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (lmc_pkg::sample_t'(sample)),
        .take         (take),
        .item_valid   (item_valid),
        .item         (item)
    );

    lmc_peak u_peak (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take),
        .count_valid  (count_valid),
        .count_stall  (count_stall),
        .maxima_count (maxima_count)
    );

endmodule

// ===== design/lmc_checker.sv =====
// Port-level checks for the 3x3 local maxima counter, bound to the top level.
module lmc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sample_stall,
    input logic                             count_valid,
    input logic                             count_stall,
    input logic [lmc_pkg::COUNT_BITS-1:0]   maxima_count
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && count_stall |=> count_valid && $stable(maxima_count))
    else $error("result changed while stalled");

    // Input backs up only behind a result that is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> count_valid && count_stall)
    else $error("input stalled with output free");

    // A count never exceeds the sample count of the largest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> maxima_count <= lmc_pkg::COUNT_BITS'(lmc_pkg::MAX_ROWS * lmc_pkg::MAX_COLS))
    else $error("count out of range");

    // A result leaves only through a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(count_valid) |-> $past(!count_stall))
    else $error("result dropped without transfer");

endmodule

bind local_maxima_counter_3x3 lmc_checker u_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the 3x3 local maxima counter: random frames against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUEUE_ROOM   = 16;
    localparam int SETTLE       = 8;

    // Block ports
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [lmc_pkg::APB_ADDR_BITS-1:0]   paddr = '0;
    logic [lmc_pkg::APB_DATA_BITS-1:0]   pwdata = '0;
    logic [lmc_pkg::APB_DATA_BITS-1:0]   prdata;
    logic                                pready;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    lmc_pkg::sample_t                    sample = '0;
    logic                                count_valid;
    logic                                count_stall = 1'b0;
    logic [lmc_pkg::COUNT_BITS-1:0]      maxima_count;

    local_maxima_counter_3x3 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .count_valid  (count_valid),
        .count_stall  (count_stall),
        .maxima_count (maxima_count)
    );

    // Stimulus and expectation stores
    lmc_pkg::sample_t               pending[$];
    logic [lmc_pkg::COUNT_BITS-1:0] frame_totals[$];
    int                             send_idle_pct = 6;
    int                             recv_stall_pct = 63;
    int                             errors = 0;
    int                             samples_taken = 0;
    int                             totals_checked = 0;
    int                             cycles = 0;

    // Predictor state: three-row circular line store, position, running total
    lmc_pkg::sample_t                rows3 [3][lmc_pkg::MAX_COLS];
    logic [lmc_pkg::NROWS_BITS-1:0]  rows_reg = 1;
    logic [lmc_pkg::NCOLS_BITS-1:0]  cols_reg = 1;
    int unsigned                     row_pos = 0;
    int unsigned                     col_pos = 0;
    logic [lmc_pkg::COUNT_BITS-1:0]  peak_total = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned eff_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > lmc_pkg::MAX_ROWS)
            return lmc_pkg::MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic int unsigned eff_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > lmc_pkg::MAX_COLS)
            return lmc_pkg::MAX_COLS;
        return 32'(cols_reg);
    endfunction

    // Peaks in row r: no in-bounds neighbor strictly greater
    function automatic int unsigned row_peaks(input int r, input int nr, input int nc);
        int unsigned found;
        logic        peak;
        int          rr;
        int          cc;
        found = 0;
        for (int c = 0; c < nc; c++)
        begin
            peak = 1'b1;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    rr = r + dr;
                    cc = c + dc;
                    if (!(dr == 0 && dc == 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc &&
                        rows3[rr % 3][cc] > rows3[r % 3][c])
                        peak = 1'b0;
                end
            end
            if (peak)
                found++;
        end
        return found;
    endfunction

    // Advance the predictor by one accepted sample
    task automatic absorb_sample(input lmc_pkg::sample_t s);
        int unsigned nr;
        int unsigned nc;
        int unsigned r;
        int unsigned c;
        nr = eff_rows();
        nc = eff_cols();
        r  = (row_pos >= nr) ? 0 : row_pos;
        c  = (col_pos >= nc) ? 0 : col_pos;
        rows3[r % 3][c] = s;
        if (c + 1 < nc)
        begin
            row_pos = r;
            col_pos = c + 1;
            return;
        end
        // row above now has its full neighborhood
        if (r >= 1)
            peak_total = peak_total + lmc_pkg::COUNT_BITS'(row_peaks(r - 1, nr, nc));
        if (r + 1 < nr)
        begin
            row_pos = r + 1;
            col_pos = 0;
            return;
        end
        // end of frame
        peak_total = peak_total + lmc_pkg::COUNT_BITS'(row_peaks(r, nr, nc));
        frame_totals.push_back(peak_total);
        row_pos    = 0;
        col_pos    = 0;
        peak_total = '0;
    endtask

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                absorb_sample(sample);
                samples_taken++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    sample       <= pending.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Count monitor with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            count_stall <= 1'b0;
        end
        else
        begin
            if (count_valid && !count_stall)
            begin
                if (frame_totals.size() == 0)
                    report_mismatch($sformatf("count %0d with no frame pending", maxima_count));
                else
                begin
                    if (maxima_count !== frame_totals[0])
                        report_mismatch($sformatf("maxima_count %0d, expected %0d",
                                                  maxima_count, frame_totals[0]));
                    void'(frame_totals.pop_front());
                    totals_checked++;
                end
            end
            count_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAIL local_maxima_counter_3x3");
            $finish;
        end
    end

    // Wait until every sample is taken and every total has come out, then settle
    task automatic drain_block();
        int waited;
        waited = 0;
        while ((pending.size() > 0 || sample_valid || frame_totals.size() > 0) &&
               waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; restarts the predictor's frame
    task automatic write_reg(input lmc_pkg::reg_idx_t idx,
                             input logic [lmc_pkg::APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lmc_pkg::REG_NUM_ROWS)
            rows_reg = value[lmc_pkg::NROWS_BITS-1:0];
        else
            cols_reg = value[lmc_pkg::NCOLS_BITS-1:0];
        row_pos    = 0;
        col_pos    = 0;
        peak_total = '0;
    endtask

    task automatic set_frame(input logic [31:0] rows_word, input logic [31:0] cols_word);
        drain_block();
        write_reg(lmc_pkg::REG_NUM_ROWS, rows_word);
        write_reg(lmc_pkg::REG_NUM_COLS, cols_word);
    endtask

    task automatic feed(input lmc_pkg::sample_t s);
        while (pending.size() > QUEUE_ROOM)
            @(posedge clk);
        pending.push_back(s);
    endtask

    // mode 0: narrow values with many ties, 1: full range, 2: extremes mixed in
    function automatic lmc_pkg::sample_t pick_sample(input int mode);
        if (mode == 0)
            return lmc_pkg::sample_t'(int'($urandom_range(0, 2)) - 1);
        if (mode == 2)
        begin
            case ($urandom_range(0, 4))
                0: return lmc_pkg::sample_t'(16'h8000);
                1: return lmc_pkg::sample_t'(16'h7fff);
                2: return lmc_pkg::sample_t'(0);
                3: return lmc_pkg::sample_t'(-1);
                default: return lmc_pkg::sample_t'($urandom);
            endcase
        end
        return lmc_pkg::sample_t'($urandom);
    endfunction

    task automatic feed_random(input int n);
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            feed(pick_sample(mode));
    endtask

    initial
    begin
        int          random_sent;
        int          frames_left;
        int          n;
        int          part;
        logic [31:0] rows_word;
        logic [31:0] cols_word;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry is 1x1: every sample is a frame with one peak
        feed(lmc_pkg::sample_t'(16'h8000));
        feed(lmc_pkg::sample_t'(16'h7fff));
        feed(lmc_pkg::sample_t'(0));
        feed(lmc_pkg::sample_t'(-1));

        // Zero registers act as 1
        set_frame(0, 0);
        feed(lmc_pkg::sample_t'(5));

        // 2x2 plateau at the minimum: ties count, all four are peaks
        set_frame(2, 2);
        for (int i = 0; i < 4; i++)
            feed(lmc_pkg::sample_t'(16'h8000));

        // 3x3 with a single center peak
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            feed((i == 4) ? lmc_pkg::sample_t'(16'h7fff) : lmc_pkg::sample_t'(16'h8000));

        // Frame abandoned midway by a register write, then a fresh 2x2
        set_frame(2, 3);
        feed(lmc_pkg::sample_t'(100));
        feed(lmc_pkg::sample_t'(200));
        set_frame(2, 2);
        for (int i = 1; i <= 4; i++)
            feed(lmc_pkg::sample_t'(i));

        // Widest line, with a column count that clamps
        set_frame(1, 2047);
        feed_random(lmc_pkg::MAX_COLS);

        // Random frames: mostly small, one to four frames per geometry
        random_sent = 0;
        frames_left = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (random_sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 63;
                recv_stall_pct = 6;
            end
            if (frames_left == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    rows_word = $urandom_range(0, 3);
                    cols_word = $urandom_range(13, 64);
                end
                else
                begin
                    rows_word = $urandom_range(0, 6);
                    cols_word = $urandom_range(0, 12);
                end
                // junk above the register width is dropped
                if ($urandom_range(0, 3) == 0)
                begin
                    rows_word = rows_word | ($urandom << lmc_pkg::NROWS_BITS);
                    cols_word = cols_word | ($urandom << lmc_pkg::NCOLS_BITS);
                end
                set_frame(rows_word, cols_word);
                frames_left = $urandom_range(1, 4);
            end
            n = eff_rows() * eff_cols();
            if (n > 1 && $urandom_range(0, 19) == 0)
            begin
                // broken frame, cut short by the next register write
                part = $urandom_range(1, n - 1);
                feed_random(part);
                random_sent += part;
                frames_left = 0;
            end
            else
            begin
                feed_random(n);
                random_sent += n;
                frames_left--;
            end
        end

        drain_block();
        if (frame_totals.size() > 0)
            report_mismatch($sformatf("%0d frame totals never came out", frame_totals.size()));

        $display("Run covered %0d samples and %0d frame totals over directed, clamped and",
                 samples_taken, totals_checked);
        $display("random geometries with three idle and stall profiles; %0d errors", errors);
        if (errors == 0)
            $display("PASS local_maxima_counter_3x3");
        else
            $display("FAIL local_maxima_counter_3x3");
        $finish;
    end

endmodule
